>>> rtl/core/binary_min_heap_queue_top_macros.svh
// Assertion macros shared by the checker of the heap queue.
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH

// Check a property at every rising edge, reset or not.
`define BMHQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Check a property at every rising edge, skipped while reset is high.
`define BMHQ_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> rtl/core/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types, codes and field widths shared by the heap queue modules.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 64;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned OCC_W    = 7;
   localparam int unsigned STATUS_W = 2;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic        [COUNT_W-1:0] count;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic      mode;
      entry_type entry;
   } request_type;

   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] top_value;
      logic        [COUNT_W-1:0] top_count;
      logic        [OCC_W-1:0]   occupancy;
      logic        [STATUS_W-1:0] status;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_RD,
      ST_POP_LD,
      ST_DN_RD,
      ST_DN_CMP,
      ST_WR_FINAL,
      ST_DONE
   } state_type;

endpackage

>>> rtl/core/binary_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top
// Binary min-heap priority queue of (value, count) entries in one RAM.
// ----------------------------------------------------------------------------
// Usage
//   Request words: drive req_mode (0 push, 1 pop), req_entry_value and
//   req_entry_count and raise start; the word is taken at the rising edge
//   where start is high and busy is low. Value and count are ignored on pop.
//   Response words: rsp_valid is high for exactly one cycle per request and
//   carries the minimum entry (zero when empty), the occupancy (entry count
//   modulo 128) and a status: ok, underflow on an empty pop (nothing
//   changes) or overflow on a full push (the entry is dropped).
//   Sequence: a rejected request goes straight to its response; a push
//   reads and compares parents while it rises, then writes the entry;
//   a pop reads the last entry and, unless that empties the heap, sinks
//   it from the root, reading and comparing each level, then writes it.
//   Each level takes one RAM read and a compare on its registered data.
//   Throughput: one request at a time; the next start is taken in the same
//   cycle as the strobe of the previous one.
//   Reset: synchronous, clears the state machine and entry count; the heap
//   RAM needs no clearing pass, as only written slots are ever read.
//   The receiver cannot stall: each response word is shown once only.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_top #(
   parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_mode,
   input  logic signed [bmhq_pkg::VALUE_W-1:0]  req_entry_value,
   input  logic        [bmhq_pkg::COUNT_W-1:0]  req_entry_count,
   output logic                                 rsp_valid,
   output logic signed [bmhq_pkg::VALUE_W-1:0]  rsp_top_value,
   output logic        [bmhq_pkg::COUNT_W-1:0]  rsp_top_count,
   output logic        [bmhq_pkg::OCC_W-1:0]    rsp_occupancy,
   output logic        [bmhq_pkg::STATUS_W-1:0] rsp_status
);

   import bmhq_pkg::*;

   request_type          req;
   result_type           result;
   logic                 engine_busy;

   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_top_value_ff;
   logic        [COUNT_W-1:0] rsp_top_count_ff;
   logic        [OCC_W-1:0]   rsp_occupancy_ff;
   logic        [STATUS_W-1:0] rsp_status_ff;

   // pack the request word for the sequencer
   assign req.mode        = req_mode;
   assign req.entry.value = req_entry_value;
   assign req.entry.count = req_entry_count;

   bmhq_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req),
      .busy   (engine_busy),
      .result (result)
   );

   // hold off requests while reset is applied as well
   assign busy = engine_busy || reset;

   // register the response word: strobe for one cycle, payload held after
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= result.valid;
      end
      if (result.valid) begin
         rsp_top_value_ff <= result.top_value;
         rsp_top_count_ff <= result.top_count;
         rsp_occupancy_ff <= result.occupancy;
         rsp_status_ff    <= result.status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_value_ff;
   assign rsp_top_count = rsp_top_count_ff;
   assign rsp_occupancy = rsp_occupancy_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

>>> rtl/core/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data0,
   output logic [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data0_ff <= mem_ff[rd_addr0];
      rd_data1_ff <= mem_ff[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

>>> rtl/core/bmhq_engine.sv
// ----------------------------------------------------------------------------
// bmhq_engine
// Sequencer that sifts entries up or down through the heap memory.
// ----------------------------------------------------------------------------
module bmhq_engine #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  bmhq_pkg::request_type             req,
   output logic                              busy,
   output bmhq_pkg::result_type              result
);

   import bmhq_pkg::*;

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = AW + 2;

   state_type            state_ff, state_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        total_ff, total_in;
   entry_type            cur_ff, cur_in;
   entry_type            root_ff, root_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [ENTRY_W-1:0]   ram_wdata;
   logic [AW-1:0]        ram_raddr0;
   logic [AW-1:0]        ram_raddr1;
   logic [ENTRY_W-1:0]   ram_rdata0;
   logic [ENTRY_W-1:0]   ram_rdata1;

   entry_type            ent0;
   entry_type            ent1;
   logic [AW-1:0]        parent_idx;
   logic [IW-1:0]        left_idx;
   logic [IW-1:0]        right_idx;
   logic [IW-1:0]        total_w;
   logic                 left_ok;
   logic                 right_ok;
   logic                 pick_left;
   logic                 pick_right;
   logic signed [VALUE_W-1:0] min_value;
   logic                 parent_greater;
   logic                 heap_full;
   logic                 accept;

   bmhq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock    (clock),
      .wr_en    (ram_we),
      .wr_addr  (ram_waddr),
      .wr_data  (ram_wdata),
      .rd_addr0 (ram_raddr0),
      .rd_addr1 (ram_raddr1),
      .rd_data0 (ram_rdata0),
      .rd_data1 (ram_rdata1)
   );

   assign ent0       = entry_type'(ram_rdata0);
   assign ent1       = entry_type'(ram_rdata1);
   assign parent_idx = AW'((pos_ff - 1'b1) >> 1);
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + 1'b1;
   assign total_w    = IW'(total_ff);
   assign left_ok    = left_idx < total_w;
   assign right_ok   = right_idx < total_w;
   assign pick_left  = ent0.value < cur_ff.value;
   assign min_value  = pick_left ? ent0.value : cur_ff.value;
   assign pick_right = right_ok && (ent1.value < min_value);
   assign parent_greater = ent0.value > cur_ff.value;
   assign heap_full  = total_ff == CW'(CAPACITY);
   assign accept     = start && (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req.mode == MODE_PUSH) begin
                  if (heap_full) begin
                     state_in = ST_DONE;
                  end else if (total_ff == '0) begin
                     state_in = ST_WR_FINAL;
                  end else begin
                     state_in = ST_UP_RD;
                  end
               end else begin
                  state_in = (total_ff == '0) ? ST_DONE : ST_POP_RD;
               end
            end
         end
         ST_UP_RD:  state_in = ST_UP_CMP;
         ST_UP_CMP: begin
            if (parent_greater && (parent_idx != '0)) begin
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_WR_FINAL;
            end
         end
         ST_POP_RD: state_in = ST_POP_LD;
         ST_POP_LD: state_in = (total_ff == '0) ? ST_DONE : ST_DN_RD;
         ST_DN_RD:  state_in = left_ok ? ST_DN_CMP : ST_WR_FINAL;
         ST_DN_CMP: state_in = (pick_left || pick_right) ? ST_DN_RD : ST_WR_FINAL;
         ST_WR_FINAL: state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // memory control and result
   always_comb begin
      ram_we     = 1'b0;
      ram_waddr  = pos_ff;
      ram_wdata  = cur_ff;
      ram_raddr0 = parent_idx;
      ram_raddr1 = right_idx[AW-1:0];
      unique case (state_ff)
         ST_UP_CMP: begin
            ram_we    = parent_greater;
            ram_wdata = ent0;
         end
         ST_POP_RD: ram_raddr0 = AW'(total_ff);
         ST_DN_RD:  ram_raddr0 = left_idx[AW-1:0];
         ST_DN_CMP: begin
            ram_we    = pick_left || pick_right;
            ram_wdata = pick_right ? ent1 : ent0;
         end
         ST_WR_FINAL: ram_we = 1'b1;
         default: ;
      endcase

      busy             = state_ff != ST_IDLE;
      result.valid     = state_ff == ST_DONE;
      result.top_value = (total_ff != '0) ? root_ff.value : '0;
      result.top_count = (total_ff != '0) ? root_ff.count : '0;
      result.occupancy = OCC_W'(total_ff);
      result.status    = status_ff;
   end

   // datapath next values
   always_comb begin
      pos_in    = pos_ff;
      total_in  = total_ff;
      cur_in    = cur_ff;
      status_in = status_ff;
      root_in   = root_ff;
      if (accept) begin
         status_in = STATUS_OK;
         if (req.mode == MODE_PUSH) begin
            if (heap_full) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               pos_in   = AW'(total_ff);
               total_in = total_ff + 1'b1;
               cur_in   = req.entry;
            end
         end else begin
            if (total_ff == '0) begin
               status_in = STATUS_UNDERFLOW;
            end else begin
               total_in = total_ff - 1'b1;
            end
         end
      end
      if (state_ff == ST_UP_CMP && parent_greater) begin
         pos_in = parent_idx;
      end
      if (state_ff == ST_POP_LD) begin
         cur_in = ent0;
         pos_in = '0;
      end
      if (state_ff == ST_DN_CMP && (pick_left || pick_right)) begin
         pos_in = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
      end
      // shadow the root slot so the minimum is ready without a read
      if (ram_we && ram_waddr == '0) begin
         root_in = entry_type'(ram_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
      end
      pos_ff    <= pos_in;
      cur_ff    <= cur_in;
      root_ff   <= root_in;
      status_ff <= status_in;
   end

endmodule

>>> rtl/core/bmhq_checker.sv
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks on the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_top_macros.svh"

module bmhq_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_valid,
   input logic signed [bmhq_pkg::VALUE_W-1:0]  rsp_top_value,
   input logic        [bmhq_pkg::COUNT_W-1:0]  rsp_top_count,
   input logic        [bmhq_pkg::OCC_W-1:0]    rsp_occupancy,
   input logic        [bmhq_pkg::STATUS_W-1:0] rsp_status
);

   import bmhq_pkg::*;

   `BMHQ_ASSERT_RST(a_accept_busy, clock, reset, (start && !busy) |=> busy, "busy low after accept")

   `BMHQ_ASSERT_ALWAYS(a_rsp_idle, clock, rsp_valid |-> !busy, "response shown while busy")

   `BMHQ_ASSERT_RST(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "response strobe too long")

   `BMHQ_ASSERT_RST(a_underflow_empty, clock, reset, (rsp_valid && rsp_status == STATUS_UNDERFLOW) |-> (rsp_occupancy == '0 && rsp_top_value == '0 && rsp_top_count == '0), "underflow with entries held")

endmodule

bind binary_min_heap_queue_top bmhq_checker u_bmhq_checker (.*);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binary min-heap queue: a short table of
// directed words (empty pops, key extremes, ties), then about 600 random
// words in fill, drain and mixed phases. Every result is checked against a
// shadow heap kept in the bench, or against the result typed in its row.
// ----------------------------------------------------------------------------
module testbench;
   import bmhq_pkg::*;

   localparam int unsigned HEAP_DEPTH   = CAPACITY_DEFAULT;
   localparam int          RANDOM_WORDS = 600;
   localparam int          QUIET_TAIL   = 100;  // last words sent back to back
   localparam int          DRAIN_LIMIT  = 2000;
   localparam int          SETTLE       = 20;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  top_value;
      logic        [COUNT_W-1:0]  top_count;
      logic        [OCC_W-1:0]    occupancy;
      logic        [STATUS_W-1:0] status;
   } heap_top_type;

   typedef struct {
      logic                      mode;
      logic signed [VALUE_W-1:0] value;
      logic        [COUNT_W-1:0] count;
      bit                        typed;
      heap_top_type              want;
   } tab_row_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic                       req_mode;
   logic signed [VALUE_W-1:0]  req_entry_value;
   logic        [COUNT_W-1:0]  req_entry_count;
   logic                       rsp_valid;
   logic signed [VALUE_W-1:0]  rsp_top_value;
   logic        [COUNT_W-1:0]  rsp_top_count;
   logic        [OCC_W-1:0]    rsp_occupancy;
   logic        [STATUS_W-1:0] rsp_status;

   // Result typed into the table for the word now on the request ports
   bit           row_typed;
   heap_top_type row_want;

   // Shadow copy of the heap, advanced once per accepted word
   entry_type   shadow_heap [HEAP_DEPTH];
   int unsigned shadow_total;

   heap_top_type awaited_tops [$];
   tab_row_type  directed_rows [$];

   int fail_count;
   int pushes_sent;
   int pops_sent;
   int underflows_seen;
   int overflows_seen;
   int tops_checked;
   int peak_total;

   binary_min_heap_queue_top #(
      .CAPACITY (HEAP_DEPTH)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_entry_value (req_entry_value),
      .req_entry_count (req_entry_count),
      .rsp_valid       (rsp_valid),
      .rsp_top_value   (rsp_top_value),
      .rsp_top_count   (rsp_top_count),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_status      (rsp_status)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one word to the shadow heap and return the minimum, occupancy
   // and status that the block must report for it.
   function automatic heap_top_type heap_op_outcome(input logic                      mode,
                                                    input logic signed [VALUE_W-1:0] value,
                                                    input logic        [COUNT_W-1:0] count);
      heap_top_type res;
      entry_type    tmp;
      int unsigned  pos;
      int unsigned  parent;
      int unsigned  lc;
      int unsigned  rc;
      int unsigned  pick;
      res.status = STATUS_OK;
      if (mode == MODE_PUSH) begin
         if (shadow_total >= HEAP_DEPTH) begin
            // Full: drop the entry, leave the heap untouched
            res.status = STATUS_OVERFLOW;
         end else begin
            tmp.value = value;
            tmp.count = count;
            shadow_heap[shadow_total] = tmp;
            pos = shadow_total;
            shadow_total++;
            // Rise only while the parent is strictly greater
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if ($signed(shadow_heap[parent].value) > $signed(shadow_heap[pos].value)) begin
                  tmp = shadow_heap[parent];
                  shadow_heap[parent] = shadow_heap[pos];
                  shadow_heap[pos] = tmp;
                  pos = parent;
               end else begin
                  break;
               end
            end
         end
      end else begin
         if (shadow_total == 0) begin
            res.status = STATUS_UNDERFLOW;
         end else begin
            shadow_heap[0] = shadow_heap[shadow_total - 1];
            shadow_total--;
            pos = 0;
            // Sink: left child wins a tie, right child only if strictly smaller
            while (pos < shadow_total) begin
               lc = 2 * pos + 1;
               rc = 2 * pos + 2;
               pick = pos;
               if (lc < shadow_total &&
                   $signed(shadow_heap[lc].value) < $signed(shadow_heap[pick].value))
                  pick = lc;
               if (rc < shadow_total &&
                   $signed(shadow_heap[rc].value) < $signed(shadow_heap[pick].value))
                  pick = rc;
               if (pick == pos)
                  break;
               tmp = shadow_heap[pos];
               shadow_heap[pos] = shadow_heap[pick];
               shadow_heap[pick] = tmp;
               pos = pick;
            end
         end
      end
      if (shadow_total > 0) begin
         res.top_value = shadow_heap[0].value;
         res.top_count = shadow_heap[0].count;
      end else begin
         res.top_value = '0;
         res.top_count = '0;
      end
      res.occupancy = shadow_total[OCC_W-1:0];
      return res;
   endfunction

   function automatic void add_row(input logic                      mode,
                                   input logic signed [VALUE_W-1:0] value,
                                   input logic        [COUNT_W-1:0] count,
                                   input bit                        typed,
                                   input logic signed [VALUE_W-1:0] want_value,
                                   input logic        [COUNT_W-1:0] want_count,
                                   input logic        [OCC_W-1:0]   want_occ,
                                   input logic        [STATUS_W-1:0] want_status);
      tab_row_type row;
      row.mode = mode;
      row.value = value;
      row.count = count;
      row.typed = typed;
      row.want.top_value = want_value;
      row.want.top_count = want_count;
      row.want.occupancy = want_occ;
      row.want.status = want_status;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Present one word from the falling edge and hold it until the block takes
   // it. Start is left high so that a following word keeps it up unbroken.
   task automatic send_word(input logic                      mode,
                            input logic signed [VALUE_W-1:0] value,
                            input logic        [COUNT_W-1:0] count,
                            input bit                        typed,
                            input heap_top_type              want);
      @(negedge clock);
      start           <= 1'b1;
      req_mode        <= mode;
      req_entry_value <= value;
      req_entry_count <= count;
      row_typed       <= typed;
      row_want        <= want;
      do
         @(posedge clock);
      while (busy);
   endtask

   // Drop start for a burst of idle cycles.
   task automatic hold_off(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Monitor: check the result strobe first, then log any word taken at this
   // edge. A word taken now cannot have its result in the same cycle, so the
   // oldest expectation is always the one the strobe belongs to.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      heap_top_type got;
      heap_top_type want;
      heap_top_type predicted;
      if (!reset) begin
         if (rsp_valid) begin
            got.top_value = rsp_top_value;
            got.top_count = rsp_top_count;
            got.occupancy = rsp_occupancy;
            got.status    = rsp_status;
            if (awaited_tops.size() == 0) begin
               $error("result word with nothing awaited: value %0d count %0d occ %0d status %0d",
                      got.top_value, got.top_count, got.occupancy, got.status);
               fail_count++;
            end else begin
               want = awaited_tops.pop_front();
               tops_checked++;
               if (got.top_value !== want.top_value) begin
                  $error("top_value: expected %0d, got %0d", want.top_value, got.top_value);
                  fail_count++;
               end
               if (got.top_count !== want.top_count) begin
                  $error("top_count: expected %0d, got %0d", want.top_count, got.top_count);
                  fail_count++;
               end
               if (got.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            // Advance the shadow heap on every word; rows with a typed result
            // are held to that result instead of the prediction.
            predicted = heap_op_outcome(req_mode, req_entry_value, req_entry_count);
            awaited_tops.insert(awaited_tops.size(), row_typed ? row_want : predicted);
            if (req_mode == MODE_PUSH)
               pushes_sent++;
            else
               pops_sent++;
            if (predicted.status == STATUS_UNDERFLOW)
               underflows_seen++;
            if (predicted.status == STATUS_OVERFLOW)
               overflows_seen++;
            if (shadow_total > peak_total)
               peak_total = shadow_total;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      heap_top_type              no_want;
      logic                      mode;
      logic signed [VALUE_W-1:0] value;
      logic        [COUNT_W-1:0] count;
      int                        sent;
      int                        phase_len;
      int                        phase_kind;
      int                        push_pct;
      int                        idle_pct;
      int                        pick;
      int                        k;

      no_want         = '0;
      shadow_total    = 0;
      fail_count      = 0;
      pushes_sent     = 0;
      pops_sent       = 0;
      underflows_seen = 0;
      overflows_seen  = 0;
      tops_checked    = 0;
      peak_total      = 0;

      reset           <= 1'b1;
      start           <= 1'b0;
      req_mode        <= MODE_PUSH;
      req_entry_value <= '0;
      req_entry_count <= '0;
      row_typed       <= 1'b0;
      row_want        <= '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words. Pops carry junk in value and count, which must be
      // ignored. Equal keys 3 test that a push stops at an equal parent and
      // that a sink takes the left child on a tie.
      add_row(MODE_POP,  32'sh5A5A_5A5A, 16'hA5A5, 1, 0, 0, 0, STATUS_UNDERFLOW);
      add_row(MODE_PUSH, 32'sh7FFF_FFFF, 16'hFFFF, 1, 32'sh7FFF_FFFF, 16'hFFFF, 1, STATUS_OK);
      add_row(MODE_PUSH, 32'sh8000_0000, 16'h0000, 1, 32'sh8000_0000, 16'h0000, 2, STATUS_OK);
      add_row(MODE_PUSH, 32'sh8000_0000, 16'h0001, 1, 32'sh8000_0000, 16'h0000, 3, STATUS_OK);
      add_row(MODE_PUSH, 32'sd0,         16'd5,    0, 0, 0, 0, STATUS_OK);
      add_row(MODE_PUSH, -32'sd1,        16'd7,    0, 0, 0, 0, STATUS_OK);
      add_row(MODE_PUSH, 32'sd3,         16'd10,   0, 0, 0, 0, STATUS_OK);
      add_row(MODE_PUSH, 32'sd3,         16'd11,   0, 0, 0, 0, STATUS_OK);
      add_row(MODE_PUSH, 32'sd3,         16'd12,   0, 0, 0, 0, STATUS_OK);
      add_row(MODE_PUSH, 32'sd3,         16'd13,   0, 0, 0, 0, STATUS_OK);
      for (k = 0; k < 8; k++)
         add_row(MODE_POP, $urandom, COUNT_W'($urandom_range(0, 65535)), 0, 0, 0, 0,
                 STATUS_OK);
      add_row(MODE_POP,  32'shFFFF_FFFF, 16'hFFFF, 1, 0, 0, 0, STATUS_OK);
      add_row(MODE_POP,  32'sh0000_0000, 16'h0000, 1, 0, 0, 0, STATUS_UNDERFLOW);
      add_row(MODE_PUSH, 32'sd0,         16'd0,    1, 0, 0, 1, STATUS_OK);
      add_row(MODE_POP,  32'sh1234_5678, 16'h9ABC, 1, 0, 0, 0, STATUS_OK);

      foreach (directed_rows[i]) begin
         if ($urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 10));
         send_word(directed_rows[i].mode, directed_rows[i].value, directed_rows[i].count,
                   directed_rows[i].typed, directed_rows[i].want);
      end

      // Random words in phases: fill (mostly pushes, runs into overflow),
      // drain (mostly pops, runs into underflow) and mixed. Some phases idle
      // in bursts, others run flat out; the tail never idles.
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         phase_kind = $urandom_range(0, 2);
         phase_len  = $urandom_range(40, 120);
         push_pct   = (phase_kind == 0) ? 90 : (phase_kind == 1) ? 12 : 50;
         idle_pct   = ($urandom_range(0, 1) == 0) ? 0 : 25;
         for (k = 0; k < phase_len && sent < RANDOM_WORDS; k++) begin
            mode = ($urandom_range(1, 100) <= push_pct) ? MODE_PUSH : MODE_POP;
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               // Narrow keys: plenty of ties
               value = $signed($urandom_range(0, 16)) - 8;
            end else if (pick == 4) begin
               case ($urandom_range(0, 3))
                  0: value = 32'sh8000_0000;
                  1: value = 32'sh7FFF_FFFF;
                  2: value = 32'sd0;
                  default: value = -32'sd1;
               endcase
            end else begin
               value = $urandom;
            end
            count = COUNT_W'($urandom_range(0, 65535));
            if (sent < RANDOM_WORDS - QUIET_TAIL && $urandom_range(1, 100) <= idle_pct)
               hold_off($urandom_range(1, 10));
            send_word(mode, value, count, 1'b0, no_want);
            sent++;
         end
      end

      @(negedge clock);
      start <= 1'b0;

      // Let the last results arrive, then a few more cycles for any stray one
      for (k = 0; k < DRAIN_LIMIT && awaited_tops.size() != 0; k++)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (awaited_tops.size() != 0) begin
         $error("%0d result words never arrived", awaited_tops.size());
         fail_count++;
      end

      $display("Covered %0d pushes and %0d pops, %0d underflows, %0d overflows.",
               pushes_sent, pops_sent, underflows_seen, overflows_seen);
      $display("Checked %0d result words, peak occupancy %0d of %0d.",
               tops_checked, peak_total, HEAP_DEPTH);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Hard stop far beyond the slowest legal run
   initial begin
      #(12 * 250000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_ram.sv
rtl/core/bmhq_engine.sv
rtl/core/binary_min_heap_queue_top.sv
rtl/core/bmhq_checker.sv
tb/testbench.sv
